>>> rtl/rbsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray / box slab intersection package
// Shared codes for the slab test: face codes and register indexes.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   // Width of the register index on the configuration port.
   localparam int CSR_INDEX_WIDTH = 3;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CENTER_X = 3'd0,
      CSR_CENTER_Y = 3'd1,
      CSR_CENTER_Z = 3'd2,
      CSR_HALF_X   = 3'd3,
      CSR_HALF_Y   = 3'd4,
      CSR_HALF_Z   = 3'd5
   } csr_reg_type;

   // Face through which the ray enters the box.
   typedef enum logic [2:0] {
      FACE_NEG_X = 3'd0,
      FACE_POS_X = 3'd1,
      FACE_NEG_Y = 3'd2,
      FACE_POS_Y = 3'd3,
      FACE_NEG_Z = 3'd4,
      FACE_POS_Z = 3'd5
   } face_type;

endpackage
`default_nettype wire

>>> rtl/ray_box_slab_intersect_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ray / axis-aligned box slab intersection unit
// Tests a moving point against one box held in registers and returns the
// entry time, hit point, velocity at entry and entered face.
// ----------------------------------------------------------------------------
// Usage:
// The box is written through the csr_ channel (index 0..2 center, 3..5 half
// extents) while no ray is in flight; csr_ready is always high.
// Rays enter on the req_ channel, one word per cycle when req_stall is low.
// Each ray gives exactly one word on the rsp_ channel, in order; a miss
// returns all fields zero.
// Most of the pipeline depth from acceptance to rsp_valid comes from the
// six pipelined dividers, one quotient bit per stage. The unit takes one
// ray per cycle while req_stall is low.
// When rsp_stall holds a result, the next result parks in a skid register
// and the pipeline then freezes; req_stall is high while the skid register
// is full. Reset clears the box registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [rbsi_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [COORD_WIDTH-1:0]               csr_data,
   // Ray input
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [COORD_WIDTH-1:0]        req_start_x,
   input  wire logic signed [COORD_WIDTH-1:0]        req_start_y,
   input  wire logic signed [COORD_WIDTH-1:0]        req_start_z,
   input  wire logic signed [COORD_WIDTH-1:0]        req_speed_x,
   input  wire logic signed [COORD_WIDTH-1:0]        req_speed_y,
   input  wire logic signed [COORD_WIDTH-1:0]        req_speed_z,
   input  wire logic signed [COORD_WIDTH-1:0]        req_accel_x,
   input  wire logic signed [COORD_WIDTH-1:0]        req_accel_y,
   input  wire logic signed [COORD_WIDTH-1:0]        req_accel_z,
   input  wire logic [COORD_WIDTH-2:0]               req_time_limit,
   // Result output
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_hit,
   output logic [COORD_WIDTH-2:0]                    rsp_entry_time,
   output logic signed [COORD_WIDTH-1:0]             rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0]             rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0]             rsp_hit_z,
   output logic signed [COORD_WIDTH-1:0]             rsp_out_vel_x,
   output logic signed [COORD_WIDTH-1:0]             rsp_out_vel_y,
   output logic signed [COORD_WIDTH-1:0]             rsp_out_vel_z,
   output rbsi_pkg::face_type                        rsp_face
);

   import rbsi_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int F  = FRAC_BITS;
   localparam int LW = W - 1;          // time width
   localparam int DW = W + 2;          // signed face distance
   localparam int MW = W + 1;          // distance magnitude
   localparam int NW = MW + F;         // dividend / quotient magnitude
   localparam int QW = NW + 1;         // signed face time
   localparam int SW = 2 * W - F + 1;  // sum before saturation

   typedef struct packed {
      logic [2:0][W-1:0] p;
      logic [2:0][W-1:0] v;
      logic [2:0][W-1:0] a;
      logic [LW-1:0]     limit;
   } ray_type;

   typedef struct packed {
      logic       out_slab;
      logic [2:0] moving;
      logic [2:0] neg_lo;
      logic [2:0] neg_hi;
   } flag_type;

   typedef struct packed {
      logic              hit;
      logic [LW-1:0]     entry;
      logic [2:0][W-1:0] pos;
      logic [2:0][W-1:0] vel;
      face_type          face;
   } result_type;

   // Saturating p + floor(prod / 2^F).
   function automatic logic [W-1:0] sat_add(input logic [W-1:0] base,
                                             input logic [2*W-1:0] prod);
      logic signed [SW-1:0] sum;
      logic signed [SW-1:0] smax;
      logic signed [SW-1:0] smin;
      sum  = SW'(signed'(base)) + SW'(signed'(prod) >>> F);
      smax = SW'(signed'({1'b0, {(W-1){1'b1}}}));
      smin = SW'(signed'({1'b1, {(W-1){1'b0}}}));
      if (sum > smax) begin
         return smax[W-1:0];
      end else if (sum < smin) begin
         return smin[W-1:0];
      end
      return sum[W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [2:0][W-1:0]  center_ff;
   logic [2:0][LW-1:0] half_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         half_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CENTER_X: center_ff[0] <= csr_data;
            CSR_CENTER_Y: center_ff[1] <= csr_data;
            CSR_CENTER_Z: center_ff[2] <= csr_data;
            CSR_HALF_X:   half_ff[0]   <= csr_data[LW-1:0];
            CSR_HALF_Y:   half_ff[1]   <= csr_data[LW-1:0];
            CSR_HALF_Z:   half_ff[2]   <= csr_data[LW-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: everything advances unless the skid word is held.
   // ------------------------------------------------------------------
   logic skid_valid_ff;
   logic pipe_en;
   logic accept_in;

   assign pipe_en   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept_in = req_valid && !req_stall;

   // Stage 0: input register.
   logic    s0_valid_ff;
   ray_type s0_ray_ff;
   ray_type s0_ray_in;

   assign s0_ray_in = '{p: {req_start_z, req_start_y, req_start_x},
                        v: {req_speed_z, req_speed_y, req_speed_x},
                        a: {req_accel_z, req_accel_y, req_accel_x},
                        limit: req_time_limit};

   // Stage 1: face distances, magnitudes and quotient signs.
   logic                 s1_valid_ff;
   ray_type              s1_ray_ff;
   flag_type             s1_flags_ff;
   logic [2:0][NW-1:0]   s1_num_lo_ff, s1_num_hi_ff;
   logic [2:0][W-1:0]    s1_den_ff;
   flag_type             s1_flags_in;
   logic [2:0][NW-1:0]   s1_num_lo_in, s1_num_hi_in;
   logic [2:0][W-1:0]    s1_den_in;

   always_comb begin
      logic signed [DW-1:0] lo, hi, ps, dlo, dhi;
      logic signed [W-1:0]  vs;
      s1_flags_in = '0;
      for (int i = 0; i < 3; i++) begin
         ps  = DW'(signed'(s0_ray_ff.p[i]));
         vs  = signed'(s0_ray_ff.v[i]);
         lo  = DW'(signed'(center_ff[i])) - DW'(signed'({1'b0, half_ff[i]}));
         hi  = DW'(signed'(center_ff[i])) + DW'(signed'({1'b0, half_ff[i]}));
         dlo = lo - ps;
         dhi = hi - ps;
         s1_flags_in.moving[i] = (vs != '0);
         if (vs == '0 && (ps < lo || ps > hi)) begin
            s1_flags_in.out_slab = 1'b1;
         end
         s1_flags_in.neg_lo[i] = dlo[DW-1] ^ vs[W-1];
         s1_flags_in.neg_hi[i] = dhi[DW-1] ^ vs[W-1];
         s1_num_lo_in[i] = {(dlo[DW-1] ? MW'(-dlo) : MW'(dlo)), {F{1'b0}}};
         s1_num_hi_in[i] = {(dhi[DW-1] ? MW'(-dhi) : MW'(dhi)), {F{1'b0}}};
         s1_den_in[i]    = vs[W-1] ? W'(-vs) : W'(vs);
      end
   end

   // Dividers: time to each face, magnitude only.
   logic [2:0][NW-1:0] q_lo, q_hi;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      rbsi_div #(.NUM_WIDTH(NW), .DEN_WIDTH(W)) u_div_lo (
         .clock (clock),
         .en    (pipe_en),
         .num   (s1_num_lo_ff[i]),
         .den   (s1_den_ff[i]),
         .quo   (q_lo[i])
      );
      rbsi_div #(.NUM_WIDTH(NW), .DEN_WIDTH(W)) u_div_hi (
         .clock (clock),
         .en    (pipe_en),
         .num   (s1_num_hi_ff[i]),
         .den   (s1_den_ff[i]),
         .quo   (q_hi[i])
      );
   end

   // Side data travelling alongside the dividers.
   logic     dv_valid_ff [NW];
   ray_type  dv_ray_ff   [NW];
   flag_type dv_flags_ff [NW];

   // Stage 2: signed face times.
   logic                      s2_valid_ff;
   ray_type                   s2_ray_ff;
   flag_type                  s2_flags_ff;
   logic signed [2:0][QW-1:0] s2_tlo_ff, s2_thi_ff;
   logic signed [2:0][QW-1:0] s2_tlo_in, s2_thi_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_tlo_in[i] = dv_flags_ff[NW-1].neg_lo[i] ? -QW'(q_lo[i]) : QW'(q_lo[i]);
         s2_thi_in[i] = dv_flags_ff[NW-1].neg_hi[i] ? -QW'(q_hi[i]) : QW'(q_hi[i]);
      end
   end

   // Stage 3: near and far time per axis; idle axes give no bound.
   logic                      s3_valid_ff;
   ray_type                   s3_ray_ff;
   flag_type                  s3_flags_ff;
   logic signed [2:0][QW-1:0] s3_tlo_ff, s3_thi_ff, s3_near_ff, s3_far_ff;
   logic signed [2:0][QW-1:0] s3_near_in, s3_far_in;

   always_comb begin
      logic signed [QW-1:0] tl, th;
      for (int i = 0; i < 3; i++) begin
         tl = signed'(s2_tlo_ff[i]);
         th = signed'(s2_thi_ff[i]);
         if (!s2_flags_ff.moving[i]) begin
            s3_near_in[i] = {1'b1, {(QW-1){1'b0}}};
            s3_far_in[i]  = {1'b0, {(QW-1){1'b1}}};
         end else if (tl < th) begin
            s3_near_in[i] = tl;
            s3_far_in[i]  = th;
         end else begin
            s3_near_in[i] = th;
            s3_far_in[i]  = tl;
         end
      end
   end

   // Stage 4: entry is the latest near time, exit the earliest far time.
   logic                      s4_valid_ff;
   ray_type                   s4_ray_ff;
   flag_type                  s4_flags_ff;
   logic signed [2:0][QW-1:0] s4_tlo_ff, s4_thi_ff;
   logic signed [QW-1:0]      s4_entry_ff, s4_exit_ff;
   logic signed [QW-1:0]      s4_entry_in, s4_exit_in;

   always_comb begin
      logic signed [QW-1:0] e01, x01;
      e01 = (signed'(s3_near_ff[0]) > signed'(s3_near_ff[1])) ? s3_near_ff[0]
                                                              : s3_near_ff[1];
      x01 = (signed'(s3_far_ff[0]) < signed'(s3_far_ff[1])) ? s3_far_ff[0]
                                                            : s3_far_ff[1];
      s4_entry_in = (e01 > signed'(s3_near_ff[2])) ? e01 : s3_near_ff[2];
      s4_exit_in  = (x01 < signed'(s3_far_ff[2])) ? x01 : s3_far_ff[2];
   end

   // Stage 5: hit decision and entered face.
   logic          s5_valid_ff;
   ray_type       s5_ray_ff;
   logic          s5_hit_ff;
   logic [LW-1:0] s5_entry_ff;
   face_type      s5_face_ff;
   logic          s5_hit_in;
   face_type      s5_face_in;

   always_comb begin
      s5_hit_in = !s4_flags_ff.out_slab && (s4_flags_ff.moving != '0) &&
                  (s4_exit_ff >= s4_entry_ff) &&
                  (s4_entry_ff <= signed'(QW'({1'b0, s4_ray_ff.limit}))) &&
                  !s4_entry_ff[QW-1] && (s4_entry_ff != '0);
      // Lowest matching face wins, so scan from the top and overwrite.
      s5_face_in = FACE_NEG_X;
      for (int i = 2; i >= 0; i--) begin
         if (s4_flags_ff.moving[i]) begin
            if (signed'(s4_thi_ff[i]) == s4_entry_ff) begin
               s5_face_in = face_type'(3'(2 * i + 1));
            end
            if (signed'(s4_tlo_ff[i]) == s4_entry_ff) begin
               s5_face_in = face_type'(3'(2 * i));
            end
         end
      end
   end

   // Stage 6: products v*t and a*t.
   logic                s6_valid_ff;
   logic                s6_hit_ff;
   logic [LW-1:0]       s6_entry_ff;
   face_type            s6_face_ff;
   logic [2:0][W-1:0]   s6_p_ff, s6_v_ff;
   logic [2:0][2*W-1:0] s6_pv_ff, s6_av_ff;
   logic [2:0][2*W-1:0] s6_pv_in, s6_av_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_pv_in[i] = signed'(s5_ray_ff.v[i]) * signed'({1'b0, s5_entry_ff});
         s6_av_in[i] = signed'(s5_ray_ff.a[i]) * signed'({1'b0, s5_entry_ff});
      end
   end

   // Final sums with saturation; a miss returns all zero.
   result_type res;

   always_comb begin
      res = '0;
      if (s6_hit_ff) begin
         res.hit   = 1'b1;
         res.entry = s6_entry_ff;
         res.face  = s6_face_ff;
         for (int i = 0; i < 3; i++) begin
            res.pos[i] = sat_add(s6_p_ff[i], s6_pv_ff[i]);
            res.vel[i] = sat_add(s6_v_ff[i], s6_av_ff[i]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Pipeline data registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_ray_ff    <= s0_ray_in;
         s1_ray_ff    <= s0_ray_ff;
         s1_flags_ff  <= s1_flags_in;
         s1_num_lo_ff <= s1_num_lo_in;
         s1_num_hi_ff <= s1_num_hi_in;
         s1_den_ff    <= s1_den_in;
         s2_ray_ff    <= dv_ray_ff[NW-1];
         s2_flags_ff  <= dv_flags_ff[NW-1];
         s2_tlo_ff    <= s2_tlo_in;
         s2_thi_ff    <= s2_thi_in;
         s3_ray_ff    <= s2_ray_ff;
         s3_flags_ff  <= s2_flags_ff;
         s3_tlo_ff    <= s2_tlo_ff;
         s3_thi_ff    <= s2_thi_ff;
         s3_near_ff   <= s3_near_in;
         s3_far_ff    <= s3_far_in;
         s4_ray_ff    <= s3_ray_ff;
         s4_flags_ff  <= s3_flags_ff;
         s4_tlo_ff    <= s3_tlo_ff;
         s4_thi_ff    <= s3_thi_ff;
         s4_entry_ff  <= s4_entry_in;
         s4_exit_ff   <= s4_exit_in;
         s5_ray_ff    <= s4_ray_ff;
         s5_hit_ff    <= s5_hit_in;
         s5_entry_ff  <= s4_entry_ff[LW-1:0];
         s5_face_ff   <= s5_face_in;
         s6_hit_ff    <= s5_hit_ff;
         s6_entry_ff  <= s5_entry_ff;
         s6_face_ff   <= s5_face_ff;
         s6_p_ff      <= s5_ray_ff.p;
         s6_v_ff      <= s5_ray_ff.v;
         s6_pv_ff     <= s6_pv_in;
         s6_av_ff     <= s6_av_in;
      end
   end

   // Side data shift line next to the dividers.
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_ray_ff[0]   <= s1_ray_ff;
         dv_flags_ff[0] <= s1_flags_ff;
         for (int k = 1; k < NW; k++) begin
            dv_ray_ff[k]   <= dv_ray_ff[k-1];
            dv_flags_ff[k] <= dv_flags_ff[k-1];
         end
      end
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         for (int k = 0; k < NW; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_valid_ff    <= accept_in;
         s1_valid_ff    <= s0_valid_ff;
         dv_valid_ff[0] <= s1_valid_ff;
         for (int k = 1; k < NW; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
         s2_valid_ff <= dv_valid_ff[NW-1];
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output register and skid register
   // ------------------------------------------------------------------
   logic       rsp_valid_ff, rsp_valid_in;
   logic       skid_valid_in;
   result_type rsp_ff, rsp_in;
   result_type skid_ff, skid_in;
   logic       out_take;
   logic       arrive;

   assign out_take = rsp_valid_ff && !rsp_stall;
   assign arrive   = pipe_en && s6_valid_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_ff.hit;
   assign rsp_entry_time = rsp_ff.entry;
   assign rsp_hit_x      = rsp_ff.pos[0];
   assign rsp_hit_y      = rsp_ff.pos[1];
   assign rsp_hit_z      = rsp_ff.pos[2];
   assign rsp_out_vel_x  = rsp_ff.vel[0];
   assign rsp_out_vel_y  = rsp_ff.vel[1];
   assign rsp_out_vel_z  = rsp_ff.vel[2];
   assign rsp_face       = rsp_ff.face;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // A parked skid word always sits behind a valid output word.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held without an output word");

   // The skid register only fills while the output word is stalled.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without an output stall");

   // A hit has a positive entry time and a legal face.
   a_hit_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.hit) |->
         (rsp_ff.entry != '0 && rsp_ff.face <= FACE_POS_Z))
      else $error("hit word with zero entry time or bad face");

   // A miss returns a cleared word.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.hit) |->
         (rsp_ff.entry == '0 && rsp_ff.face == FACE_NEG_X &&
          rsp_ff.pos == '0 && rsp_ff.vel == '0))
      else $error("miss word carries nonzero fields");

endmodule
`default_nettype wire

>>> rtl/rbsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage. The stages
// advance only while en is high; the quotient is read from the last stage.
// ----------------------------------------------------------------------------
module rbsi_div #(
   parameter int NUM_WIDTH = 49,
   parameter int DEN_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic [NUM_WIDTH-1:0] num,
   input  wire logic [DEN_WIDTH-1:0] den,
   output logic      [NUM_WIDTH-1:0] quo
);

   // Partial remainder, numerator bits shifting out / quotient bits shifting in.
   logic [DEN_WIDTH-1:0] rem_ff [NUM_WIDTH];
   logic [NUM_WIDTH-1:0] nq_ff  [NUM_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff [NUM_WIDTH];

   for (genvar k = 0; k < NUM_WIDTH; k++) begin : g_step
      logic [DEN_WIDTH-1:0] rem_prev;
      logic [NUM_WIDTH-1:0] nq_prev;
      logic [DEN_WIDTH-1:0] den_prev;
      logic [DEN_WIDTH:0]   trial;
      logic                 fits;
      logic [DEN_WIDTH-1:0] rem_in;
      logic [NUM_WIDTH-1:0] nq_in;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = num;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      // Bring down the next numerator bit and subtract the divisor if it fits.
      always_comb begin
         trial  = {rem_prev, nq_prev[NUM_WIDTH-1]};
         fits   = (trial >= {1'b0, den_prev});
         rem_in = fits ? DEN_WIDTH'(trial - {1'b0, den_prev}) : DEN_WIDTH'(trial);
         nq_in  = {nq_prev[NUM_WIDTH-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            nq_ff[k]  <= nq_in;
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo = nq_ff[NUM_WIDTH-1];

endmodule
`default_nettype wire

>>> tb/sv/ray_box_slab_intersect_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray / box slab intersection unit testbench
// Drives rays against several box settings and checks every result word
// against a fixed-point slab-test predictor or a written expected word: a
// directed table, then random rays with random idling on both channels, a
// long result hold-off and a drain pause.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit_tb;
   import rbsi_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int LATENCY = CW + FB + 8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_RAYS = 1600;

   localparam logic signed [63:0] SMAX = 64'sd2147483647;
   localparam logic signed [63:0] SMIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [CW-1:0] sx, sy, sz, vx, vy, vz, ax, ay, az;
      logic [CW-2:0]        tlim;
   } ray_word_type;

   typedef struct packed {
      logic                 hit;
      logic [CW-2:0]        entry;
      logic signed [CW-1:0] px, py, pz, qx, qy, qz;
      face_type             face;
   } hit_word_type;

   // A directed row: a ray, plus an expected word when it is known at a glance.
   typedef struct {
      ray_word_type ray;
      bit           typed;
      hit_word_type want;
   } ray_row_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CW-1:0] csr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   ray_word_type ray_q = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   hit_word_type got;

   ray_box_slab_intersect_unit u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_x(ray_q.sx), .req_start_y(ray_q.sy), .req_start_z(ray_q.sz),
      .req_speed_x(ray_q.vx), .req_speed_y(ray_q.vy), .req_speed_z(ray_q.vz),
      .req_accel_x(ray_q.ax), .req_accel_y(ray_q.ay), .req_accel_z(ray_q.az),
      .req_time_limit(ray_q.tlim),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_hit(got.hit), .rsp_entry_time(got.entry),
      .rsp_hit_x(got.px), .rsp_hit_y(got.py), .rsp_hit_z(got.pz),
      .rsp_out_vel_x(got.qx), .rsp_out_vel_y(got.qy), .rsp_out_vel_z(got.qz),
      .rsp_face(got.face)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Box held by the predictor.
   logic signed [63:0] box_ctr [3];
   logic signed [63:0] box_half [3];

   hit_word_type pending_hits[$];
   int  fail_count = 0;
   int  idle_cycles = 0;
   bit  rsp_quiet = 0;     // no random result stalls
   bit  rsp_holdoff = 0;   // request for a long result hold-off
   int  idle_pct = 24;

   function automatic logic signed [63:0] floor_q(input logic signed [127:0] x);
      floor_q = 64'(x >>> FB);
   endfunction

   function automatic logic signed [63:0] clamp(input logic signed [63:0] x);
      if (x > SMAX) clamp = SMAX;
      else if (x < SMIN) clamp = SMIN;
      else clamp = x;
   endfunction

   // Slab test in fixed point: per-axis face times, entry/exit, hit point.
   function automatic hit_word_type slab_test(input ray_word_type r);
      hit_word_type w;
      logic signed [63:0] p [3], v [3], a [3], tl [3], th [3];
      logic signed [63:0] lo, hi, nr, fr, entry, leave;
      bit moving [3];
      bit miss, have, found;
      w = '0;
      miss = 0; have = 0; found = 0; entry = 0; leave = 0;
      p[0] = 64'(r.sx); p[1] = 64'(r.sy); p[2] = 64'(r.sz);
      v[0] = 64'(r.vx); v[1] = 64'(r.vy); v[2] = 64'(r.vz);
      a[0] = 64'(r.ax); a[1] = 64'(r.ay); a[2] = 64'(r.az);
      for (int i = 0; i < 3; i++) begin
         lo = box_ctr[i] - box_half[i];
         hi = box_ctr[i] + box_half[i];
         tl[i] = 0; th[i] = 0;
         moving[i] = (v[i] != 0);
         if (!moving[i]) begin
            if (p[i] < lo || p[i] > hi) miss = 1;
            continue;
         end
         tl[i] = ((lo - p[i]) * 64'sd65536) / v[i];
         th[i] = ((hi - p[i]) * 64'sd65536) / v[i];
         nr = (tl[i] < th[i]) ? tl[i] : th[i];
         fr = (tl[i] < th[i]) ? th[i] : tl[i];
         if (!have) begin
            entry = nr; leave = fr; have = 1;
         end else begin
            if (nr > entry) entry = nr;
            if (fr < leave) leave = fr;
         end
      end
      if (miss || !have || leave < entry || entry > $signed({33'd0, r.tlim}) || entry <= 0)
         return w;
      w.hit = 1;
      w.entry = entry[CW-2:0];
      for (int i = 0; i < 3 && !found; i++) begin
         if (!moving[i]) continue;
         if (tl[i] == entry) begin
            w.face = face_type'(3'(2 * i)); found = 1;
         end else if (th[i] == entry) begin
            w.face = face_type'(3'(2 * i + 1)); found = 1;
         end
      end
      w.px = CW'(clamp(p[0] + floor_q(128'(v[0]) * 128'(entry))));
      w.py = CW'(clamp(p[1] + floor_q(128'(v[1]) * 128'(entry))));
      w.pz = CW'(clamp(p[2] + floor_q(128'(v[2]) * 128'(entry))));
      w.qx = CW'(clamp(v[0] + floor_q(128'(a[0]) * 128'(entry))));
      w.qy = CW'(clamp(v[1] + floor_q(128'(a[1]) * 128'(entry))));
      w.qz = CW'(clamp(v[2] + floor_q(128'(a[2]) * 128'(entry))));
      return w;
   endfunction

   // Result channel: random stalls, an optional long hold-off, field checks.
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (pending_hits.size() == 0) begin
               $error("result word with none expected");
               fail_count++;
            end else begin
               hit_word_type w;
               w = pending_hits.pop_front();
               if (got.hit !== w.hit) begin
                  $error("hit: expected %0d got %0d", w.hit, got.hit); fail_count++;
               end
               if (got.entry !== w.entry) begin
                  $error("entry_time: expected %0h got %0h", w.entry, got.entry); fail_count++;
               end
               if (got.px !== w.px) begin
                  $error("hit_x: expected %0h got %0h", w.px, got.px); fail_count++;
               end
               if (got.py !== w.py) begin
                  $error("hit_y: expected %0h got %0h", w.py, got.py); fail_count++;
               end
               if (got.pz !== w.pz) begin
                  $error("hit_z: expected %0h got %0h", w.pz, got.pz); fail_count++;
               end
               if (got.qx !== w.qx) begin
                  $error("out_vel_x: expected %0h got %0h", w.qx, got.qx); fail_count++;
               end
               if (got.qy !== w.qy) begin
                  $error("out_vel_y: expected %0h got %0h", w.qy, got.qy); fail_count++;
               end
               if (got.qz !== w.qz) begin
                  $error("out_vel_z: expected %0h got %0h", w.qz, got.qz); fail_count++;
               end
               if (got.face !== w.face) begin
                  $error("face: expected %0d got %0d", w.face, got.face); fail_count++;
               end
            end
         end
         if (rsp_holdoff) begin
            rsp_stall <= 1;
            hold = 0;
            while (hold < 400) begin
               @(posedge clock);
               hold++;
            end
            rsp_holdoff = 0;
            rsp_stall <= 0;
         end else begin
            rsp_stall <= !rsp_quiet && ($urandom_range(99) < idle_pct);
         end
      end
   end

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Register write; updates the predictor's copy of the box. The caller
   // drops csr_valid after the last write of a series.
   task automatic write_box(input csr_reg_type idx, input logic [CW-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CENTER_X: box_ctr[0] = $signed(data);
         CSR_CENTER_Y: box_ctr[1] = $signed(data);
         CSR_CENTER_Z: box_ctr[2] = $signed(data);
         CSR_HALF_X:   box_half[0] = {33'd0, data[CW-2:0]};
         CSR_HALF_Y:   box_half[1] = {33'd0, data[CW-2:0]};
         CSR_HALF_Z:   box_half[2] = {33'd0, data[CW-2:0]};
         default: ;
      endcase
   endtask

   task automatic set_box(input logic [CW-1:0] cx, cy, cz, hx, hy, hz);
      write_box(CSR_CENTER_X, cx); write_box(CSR_CENTER_Y, cy);
      write_box(CSR_CENTER_Z, cz); write_box(CSR_HALF_X, hx);
      write_box(CSR_HALF_Y, hy);   write_box(CSR_HALF_Z, hz);
      csr_valid <= 0;
   endtask

   // Offer one ray, with random idle cycles ahead unless idling is off.
   // The valid stays high after acceptance until the next idle or drain.
   task automatic send_ray(input ray_word_type r, input bit typed, input hit_word_type w,
                           input bit idle);
      while (idle && $urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      ray_q <= r;
      do @(posedge clock); while (req_stall);
      pending_hits.push_back(typed ? w : slab_test(r));
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic logic signed [CW-1:0] rnd_coord(input int span);
      case ($urandom_range(5))
         0: rnd_coord = $urandom;
         1: rnd_coord = 0;
         default: rnd_coord = $signed(CW'($urandom_range(2 * span))) - span;
      endcase
   endfunction

   // Ray aimed near the box; a share are plain noise.
   function automatic ray_word_type aimed_ray;
      ray_word_type r;
      int span;
      span = 32'h00200000;
      r.sx = rnd_coord(span); r.sy = rnd_coord(span); r.sz = rnd_coord(span);
      r.vx = rnd_coord(span / 4); r.vy = rnd_coord(span / 4); r.vz = rnd_coord(span / 4);
      r.ax = rnd_coord(span); r.ay = rnd_coord(span); r.az = rnd_coord(span);
      if ($urandom_range(4) == 0) begin
         r.vx = -r.sx; r.vy = -r.sy; r.vz = -r.sz;   // heads for the origin in unit time
      end
      case ($urandom_range(3))
         0: r.tlim = 31'($urandom);
         1: r.tlim = 31'h7fffffff;
         default: r.tlim = 31'($urandom_range(32'h00100000));
      endcase
      if ($urandom_range(7) == 0) r = {$urandom, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom, 31'($urandom)};
      return r;
   endfunction

   ray_row_type rows [$];
   hit_word_type none;
   ray_word_type r;
   logic [CW-1:0] q1;

   initial begin
      none = '0;
      q1 = 32'h00010000;
      for (int i = 0; i < 3; i++) begin
         box_ctr[i] = 0; box_half[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 0;

      // Reset box is a point at the origin; a ray through it starting away.
      r = '0; r.sx = -32'sh00020000; r.vx = 32'sh00010000; r.tlim = 31'h7fffffff;
      rows.push_back('{r, 0, none});
      // All speeds zero: always a miss.
      r = '0; r.tlim = 31'h7fffffff;
      rows.push_back('{r, 1, none});
      foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].want, 0);
      drain();
      rows.delete();

      // Unit box at the origin.
      set_box(0, 0, 0, q1, q1, q1);
      // Head-on along +x from x=-3: enters the -x face at t=2, hits (-1,0,0).
      r = '0; r.sx = -32'sh00030000; r.vx = 32'sh00010000; r.ax = 32'sh00010000;
      r.tlim = 31'h7fffffff;
      rows.push_back('{r, 1, '{1, 31'h00020000, -32'sh00010000, 0, 0,
                               32'sh00030000, 0, 0, FACE_NEG_X}});
      // Same ray with the limit below the entry time: a miss.
      r.tlim = 31'h00010000;
      rows.push_back('{r, 1, none});
      // Start inside the box: a miss.
      r = '0; r.vy = 32'sh00010000; r.tlim = 31'h7fffffff;
      rows.push_back('{r, 1, none});
      // Start on a face, moving outward.
      r = '0; r.sz = 32'sh00010000; r.vz = 32'sh00010000; r.tlim = 31'h7fffffff;
      rows.push_back('{r, 1, none});
      // Zero speed on x outside the slab: a miss.
      r = '0; r.sx = 32'sh00050000; r.vy = 32'sh00010000; r.sy = -32'sh00050000;
      r.tlim = 31'h7fffffff;
      rows.push_back('{r, 1, none});
      // Zero speed on x exactly on the slab boundary.
      r.sx = 32'sh00010000;
      rows.push_back('{r, 0, none});
      // Moving away from the box.
      r = '0; r.sx = -32'sh00030000; r.vx = -32'sh00010000; r.tlim = 31'h7fffffff;
      rows.push_back('{r, 1, none});
      // Diagonal, tie between -x, -y and -z faces.
      r = '0; r.sx = -32'sh00030000; r.sy = -32'sh00030000; r.sz = -32'sh00030000;
      r.vx = 32'sh00010000; r.vy = 32'sh00010000; r.vz = 32'sh00010000;
      r.tlim = 31'h7fffffff;
      rows.push_back('{r, 0, none});
      // Entering the +x, +y and +z faces.
      r = '0; r.sx = 32'sh00040000; r.vx = -32'sh00010000; r.tlim = 31'h7fffffff;
      rows.push_back('{r, 0, none});
      r = '0; r.sy = 32'sh00040000; r.vy = -32'sh00020000; r.tlim = 31'h7fffffff;
      rows.push_back('{r, 0, none});
      r = '0; r.sz = 32'sh00040000; r.vz = -32'sh00008000; r.ay = 32'sh80000000;
      r.tlim = 31'h7fffffff;
      rows.push_back('{r, 0, none});
      // Extremes: largest speeds and accelerations, saturating outputs.
      r = '0; r.sx = 32'sh80000000; r.vx = 32'sh7fffffff; r.vy = 32'sh00000001;
      r.sy = -32'sh00010000; r.ax = 32'sh7fffffff; r.az = 32'sh80000000;
      r.vz = 32'sh80000000; r.sz = 32'sh7fffffff; r.tlim = 31'h7fffffff;
      rows.push_back('{r, 0, none});
      r = '0; r.sx = 32'sh7fffffff; r.vx = 32'sh80000000; r.ax = 32'sh80000000;
      r.tlim = 31'h7fffffff;
      rows.push_back('{r, 0, none});
      r = '0; r.sx = -32'sh00020000; r.vx = 32'sh00000001; r.ay = 32'sh7fffffff;
      r.tlim = 31'h7fffffff;
      rows.push_back('{r, 0, none});
      r = '1; r.tlim = 31'h0;
      rows.push_back('{r, 1, none});
      foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].want, 0);
      drain();

      // Extreme box: largest halves, corner centers.
      set_box(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      r = '0; r.sx = 32'sh7fffffff; r.vx = 32'sh80000000; r.tlim = 31'h7fffffff;
      send_ray(r, 0, none, 0);
      r = aimed_ray(); send_ray(r, 0, none, 0);
      drain();

      // Random phases over several boxes.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 7)
            set_box(0, 0, 0, 0, 0, 0);
         else if (phase == 6)
            set_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            set_box($urandom_range(32'h00080000) - 32'h00040000,
                    $urandom_range(32'h00080000) - 32'h00040000,
                    $urandom_range(32'h00080000) - 32'h00040000,
                    $urandom_range(32'h00060000), $urandom_range(32'h00060000),
                    $urandom_range(32'h00060000));
         rsp_quiet = (phase == 2);
         if (phase == 3) rsp_holdoff = 1;
         for (int k = 0; k < RANDOM_RAYS / 8; k++) begin
            send_ray(aimed_ray(), 0, none, phase != 2);
            // Sender waits for the block to empty once.
            if (phase == 4 && k == 50) begin
               req_valid <= 0;
               while (pending_hits.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
